// File: rtl/utrc_pkg.sv
// Shared types and constants for the chunked transmit ring.
package utrc_pkg;

  // Widest ring index the block supports (65536 entries)
  localparam int unsigned MAX_IDX_W = 16;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_OFFER = 2'd0,
    OP_KICK  = 2'd1,
    OP_DONE  = 2'd2
  } op_t;

  // Ring memory write request from the pointer logic
  typedef struct packed {
    logic                 we;
    logic [MAX_IDX_W-1:0] addr;
    logic [7:0]           data;
  } ring_wr_t;

endpackage

// File: rtl/uart_tx_ring_chunked.sv
// Transmit ring for one serial port: message intake and burst descriptors.
//
// Requests enter on start when busy is low; busy is always low, so one
// request may be taken every clock cycle. Each request gives exactly one
// result on the out_ ports in the cycle after it, marked by out_valid for a
// single cycle; the receiver cannot stall it.
// Operation offer queues one message byte: the first byte of a message
// carries the length, and the message is taken only if it is nonzero and
// fits the free space (RING_BYTES - 1 minus bytes in use), else it is
// dropped whole and out_drop_total counts it. Operation kick issues a
// descriptor for the contiguous span from the tail when no burst is in
// flight, the ring holds bytes and the start is not refused; operation
// complete retires it and moves the tail. Throughput is one request per
// cycle, set by the single memory write port and the registered pointers.
// Synchronous reset empties the ring, clears busy state and the drop
// count; the byte memory itself is not cleared and needs no sweep.
module uart_tx_ring_chunked
  import utrc_pkg::*;
#(
  parameter int unsigned RING_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic [9:0]  in_message_length,
  input  logic        in_start_refused,
  output logic        out_valid,
  output logic        out_accepted,
  output logic        out_burst_issued,
  output logic [7:0]  out_burst_start,
  output logic [7:0]  out_burst_length,
  output logic [7:0]  out_free_space,
  output logic        out_busy_res,
  output logic [31:0] out_drop_total
);

  ring_wr_t wr_req;
  logic     req_valid;

  // Take a request every cycle
  assign busy      = 1'b0;
  assign req_valid = start && !busy;

  utrc_ctrl #(
    .RING_BYTES(RING_BYTES)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .req_valid          (req_valid),
    .req_operation      (in_operation),
    .req_data_byte      (in_data_byte),
    .req_first_byte     (in_first_byte),
    .req_message_length (in_message_length),
    .req_start_refused  (in_start_refused),
    .wr_req             (wr_req),
    .res_valid          (out_valid),
    .res_accepted       (out_accepted),
    .res_burst_issued   (out_burst_issued),
    .res_burst_start    (out_burst_start),
    .res_burst_length   (out_burst_length),
    .res_free_space     (out_free_space),
    .res_busy           (out_busy_res),
    .res_drop_total     (out_drop_total)
  );

  utrc_mem #(
    .RING_BYTES(RING_BYTES)
  ) u_mem (
    .clk    (clk),
    .wr_req (wr_req)
  );

endmodule

// File: rtl/utrc_mem.sv
// Byte store of the transmit ring: one synchronous write port.
module utrc_mem
  import utrc_pkg::*;
#(
  parameter int unsigned RING_BYTES = 256
) (
  input  logic     clk,
  input  ring_wr_t wr_req
);

  localparam int unsigned IDX_W = $clog2(RING_BYTES);

  logic [7:0] mem [RING_BYTES];

  // Write the queued byte at the head slot
  always_ff @(posedge clk) begin
    if (wr_req.we) begin
      mem[wr_req.addr[IDX_W-1:0]] <= wr_req.data;
    end
  end

endmodule

// File: rtl/utrc_ctrl.sv
// Pointer, burst and drop bookkeeping for the transmit ring.
module utrc_ctrl
  import utrc_pkg::*;
#(
  parameter int unsigned RING_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        req_valid,
  input  logic [1:0]  req_operation,
  input  logic [7:0]  req_data_byte,
  input  logic        req_first_byte,
  input  logic [9:0]  req_message_length,
  input  logic        req_start_refused,
  output ring_wr_t    wr_req,
  output logic        res_valid,
  output logic        res_accepted,
  output logic        res_burst_issued,
  output logic [7:0]  res_burst_start,
  output logic [7:0]  res_burst_length,
  output logic [7:0]  res_free_space,
  output logic        res_busy,
  output logic [31:0] res_drop_total
);

  localparam int unsigned IDX_W = $clog2(RING_BYTES);
  localparam int unsigned CMP_W = ((IDX_W > 10) ? IDX_W : 10) + 1;
  localparam logic [IDX_W:0] RING_W = (IDX_W+1)'(RING_BYTES);
  localparam logic [IDX_W:0] LAST_W = (IDX_W+1)'(RING_BYTES - 1);

  // Pointer state
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] inflight_r, inflight_nxt;
  logic             busy_r, busy_nxt;
  logic [31:0]      drop_r, drop_nxt;
  logic [9:0]       remain_r, remain_nxt;
  logic             accepting_r, accepting_nxt;

  // Result registers
  logic             valid_r;
  logic             accepted_r, accepted_nxt;
  logic             issued_r, issued_nxt;
  logic [7:0]       bstart_r, bstart_nxt;
  logic [7:0]       blen_r, blen_nxt;
  logic [7:0]       free_r;

  logic [IDX_W:0]   used_cur, free_cur, used_new, free_new, span, tail_sum;
  logic [IDX_W-1:0] head_inc;
  op_t              op;

  assign op = op_t'(req_operation);

  // Free space before and after the request
  always_comb begin
    used_cur = (head_r >= tail_r) ? ({1'b0, head_r} - {1'b0, tail_r})
                                  : ({1'b0, head_r} + RING_W - {1'b0, tail_r});
    free_cur = LAST_W - used_cur;
    used_new = (head_nxt >= tail_nxt) ? ({1'b0, head_nxt} - {1'b0, tail_nxt})
                                      : ({1'b0, head_nxt} + RING_W - {1'b0, tail_nxt});
    free_new = LAST_W - used_new;
  end

  // Next state of the ring for one request
  always_comb begin
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    inflight_nxt  = inflight_r;
    busy_nxt      = busy_r;
    drop_nxt      = drop_r;
    remain_nxt    = remain_r;
    accepting_nxt = accepting_r;
    accepted_nxt  = 1'b0;
    issued_nxt    = 1'b0;
    bstart_nxt    = 8'd0;
    blen_nxt      = 8'd0;
    head_inc      = ({1'b0, head_r} == LAST_W) ? '0 : head_r + 1'b1;
    span          = (head_r > tail_r) ? ({1'b0, head_r} - {1'b0, tail_r})
                                      : (RING_W - {1'b0, tail_r});
    tail_sum      = {1'b0, tail_r} + {1'b0, inflight_r};
    wr_req.we     = 1'b0;
    wr_req.addr   = MAX_IDX_W'(head_r);
    wr_req.data   = req_data_byte;
    if (req_valid) begin
      unique case (op)
        OP_OFFER: begin
          if (req_first_byte) begin
            if (req_message_length == 10'd0 ||
                CMP_W'(req_message_length) > CMP_W'(free_cur)) begin
              // Drop the whole message
              drop_nxt      = drop_r + 32'd1;
              accepting_nxt = 1'b0;
              remain_nxt    = 10'd0;
            end else begin
              wr_req.we     = 1'b1;
              head_nxt      = head_inc;
              accepted_nxt  = 1'b1;
              remain_nxt    = req_message_length - 10'd1;
              accepting_nxt = (req_message_length != 10'd1);
            end
          end else if (accepting_r && remain_r != 10'd0) begin
            wr_req.we     = 1'b1;
            head_nxt      = head_inc;
            accepted_nxt  = 1'b1;
            remain_nxt    = remain_r - 10'd1;
            accepting_nxt = (remain_r != 10'd1);
          end
        end
        OP_KICK: begin
          if (!busy_r && head_r != tail_r) begin
            if (!req_start_refused) begin
              busy_nxt     = 1'b1;
              inflight_nxt = span[IDX_W-1:0];
              issued_nxt   = 1'b1;
              bstart_nxt   = 8'(tail_r);
              blen_nxt     = 8'(span);
            end else begin
              busy_nxt     = 1'b0;
              inflight_nxt = '0;
            end
          end
        end
        OP_DONE: begin
          // Advance the tail past the finished burst
          if (busy_r) begin
            tail_nxt     = (tail_sum >= RING_W) ? IDX_W'(tail_sum - RING_W)
                                                : tail_sum[IDX_W-1:0];
            inflight_nxt = '0;
            busy_nxt     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      inflight_r  <= '0;
      busy_r      <= 1'b0;
      drop_r      <= 32'd0;
      remain_r    <= 10'd0;
      accepting_r <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      inflight_r  <= inflight_nxt;
      busy_r      <= busy_nxt;
      drop_r      <= drop_nxt;
      remain_r    <= remain_nxt;
      accepting_r <= accepting_nxt;
      valid_r     <= req_valid;
    end
  end

  // Register the result of each request
  always_ff @(posedge clk) begin
    if (req_valid) begin
      accepted_r <= accepted_nxt;
      issued_r   <= issued_nxt;
      bstart_r   <= bstart_nxt;
      blen_r     <= blen_nxt;
      free_r     <= 8'(free_new);
    end
  end

  assign res_valid        = valid_r;
  assign res_accepted     = accepted_r;
  assign res_burst_issued = issued_r;
  assign res_burst_start  = bstart_r;
  assign res_burst_length = blen_r;
  assign res_free_space   = free_r;
  assign res_busy         = busy_r;
  assign res_drop_total   = drop_r;

  // An accepted byte only comes from an offer request
  a_accept_is_offer: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid && op != OP_OFFER |=> !accepted_r)
    else $error("byte accepted on a non-offer request");

  // An issued burst leaves the ring busy
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && issued_r |-> busy_r && inflight_r != '0)
    else $error("burst issued without busy state");

  // Idle ring holds no bytes in flight
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> inflight_r == '0)
    else $error("bytes in flight while idle");

  // Pointers stay inside the ring
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, head_r} <= LAST_W && {1'b0, tail_r} <= LAST_W)
    else $error("ring pointer out of range");

  // Head only moves on an accepted byte
  a_head_step: assert property (@(posedge clk) disable iff (!rst_n)
    head_r != $past(head_r) && $past(rst_n) |-> valid_r && accepted_r)
    else $error("head moved without an accepted byte");

endmodule

// File: tb/sv/uart_tx_ring_chunked_tb.sv
// Self-checking testbench for the chunked transmit ring: directed and random requests.
`timescale 1ns / 1ps

module uart_tx_ring_chunked_tb;
  import utrc_pkg::*;

  localparam int unsigned RING_BYTES = 256;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;
  localparam int          STALL_LIMIT = 200;

  typedef struct packed {
    logic        accepted;
    logic        burst_issued;
    logic [7:0]  burst_start;
    logic [7:0]  burst_length;
    logic [7:0]  free_space;
    logic        busy_res;
    logic [31:0] drop_total;
  } ring_status_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_operation;
  logic [7:0]  in_data_byte;
  logic        in_first_byte;
  logic [9:0]  in_message_length;
  logic        in_start_refused;
  logic        out_valid;
  logic        out_accepted;
  logic        out_burst_issued;
  logic [7:0]  out_burst_start;
  logic [7:0]  out_burst_length;
  logic [7:0]  out_free_space;
  logic        out_busy_res;
  logic [31:0] out_drop_total;

  // Predicted ring state
  int unsigned head_idx;
  int unsigned tail_idx;
  int unsigned burst_bytes;
  bit          burst_busy;
  logic [31:0] drops_pred;
  int unsigned msg_left;
  bit          msg_open;

  ring_status_t ring_status_q[$];
  int           fail_count;
  int           requests_sent;
  int           stall_cycles;
  bit           gaps_on;

  uart_tx_ring_chunked #(.RING_BYTES(RING_BYTES)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_data_byte      (in_data_byte),
    .in_first_byte     (in_first_byte),
    .in_message_length (in_message_length),
    .in_start_refused  (in_start_refused),
    .out_valid         (out_valid),
    .out_accepted      (out_accepted),
    .out_burst_issued  (out_burst_issued),
    .out_burst_start   (out_burst_start),
    .out_burst_length  (out_burst_length),
    .out_free_space    (out_free_space),
    .out_busy_res      (out_busy_res),
    .out_drop_total    (out_drop_total)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned ring_free();
    int unsigned used;
    used = (head_idx >= tail_idx) ? head_idx - tail_idx : head_idx + RING_BYTES - tail_idx;
    return RING_BYTES - 1 - used;
  endfunction

  // Advance the predicted ring by one request and return its status
  function automatic ring_status_t predict_ring_step(logic [1:0] op, logic first,
                                                     logic [9:0] len, logic refused);
    ring_status_t st;
    int unsigned  span;
    st = '0;
    case (op)
      OP_OFFER: begin
        if (first) begin
          if (len == 0 || len > ring_free()) begin
            drops_pred++;
            msg_open = 0;
            msg_left = 0;
          end else begin
            head_idx    = (head_idx + 1) % RING_BYTES;
            st.accepted = 1'b1;
            msg_left    = len - 1;
            msg_open    = (msg_left != 0);
          end
        end else if (msg_open && msg_left != 0) begin
          head_idx    = (head_idx + 1) % RING_BYTES;
          st.accepted = 1'b1;
          msg_left--;
          if (msg_left == 0) msg_open = 0;
        end
      end
      OP_KICK: begin
        if (!burst_busy && head_idx != tail_idx) begin
          span = (head_idx > tail_idx) ? head_idx - tail_idx : RING_BYTES - tail_idx;
          if (!refused) begin
            burst_busy      = 1;
            burst_bytes     = span;
            st.burst_issued = 1'b1;
            st.burst_start  = tail_idx[7:0];
            st.burst_length = span[7:0];
          end else begin
            burst_busy  = 0;
            burst_bytes = 0;
          end
        end
      end
      OP_DONE: begin
        if (burst_busy) begin
          tail_idx    = (tail_idx + burst_bytes) % RING_BYTES;
          burst_bytes = 0;
          burst_busy  = 0;
        end
      end
      default: ;
    endcase
    st.free_space = 8'(ring_free());
    st.busy_res   = burst_busy;
    st.drop_total = drops_pred;
    return st;
  endfunction

  // Drive one request, hold it until taken, then queue its expected status
  task automatic send_request(input logic [1:0] op, input logic [7:0] data, input logic first,
                              input logic [9:0] len, input logic refused);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_operation      <= op;
    in_data_byte      <= data;
    in_first_byte     <= first;
    in_message_length <= len;
    in_start_refused  <= refused;
    @(posedge clk);
    while (busy) @(posedge clk);
    ring_status_q.push_back(predict_ring_step(op, first, len, refused));
    requests_sent++;
  endtask

  // Offer a message declaring one length but sending a given number of bytes
  task automatic offer_message(input int declared, input int sent);
    send_request(OP_OFFER, 8'($urandom), 1'b1, 10'(declared), 1'($urandom));
    for (int i = 1; i < sent; i++)
      send_request(OP_OFFER, 8'($urandom), 1'b0, 10'($urandom), 1'($urandom));
  endtask

  // Hold off new requests until every expected status has come back
  task automatic drain_results();
    start <= 1'b0;
    while (ring_status_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_message_intake();
    // zero length, stray byte, oversized lengths
    send_request(OP_OFFER, 8'h00, 1'b1, 10'd0, 1'b0);
    send_request(OP_OFFER, 8'hFF, 1'b0, 10'd5, 1'b1);
    send_request(OP_OFFER, 8'hFF, 1'b1, 10'h3FF, 1'b1);
    send_request(OP_OFFER, 8'h11, 1'b0, 10'd0, 1'b0);
    send_request(OP_OFFER, 8'h5A, 1'b1, 10'(RING_BYTES), 1'b0);
    // three-byte message plus one byte beyond its length
    send_request(OP_OFFER, 8'hA5, 1'b1, 10'd3, 1'b0);
    send_request(OP_OFFER, 8'h01, 1'b0, 10'd0, 1'b0);
    send_request(OP_OFFER, 8'h80, 1'b0, 10'h3FF, 1'b1);
    send_request(OP_OFFER, 8'h7E, 1'b0, 10'd0, 1'b0);
    // new message cuts into an open one
    send_request(OP_OFFER, 8'h33, 1'b1, 10'd4, 1'b0);
    send_request(OP_OFFER, 8'h44, 1'b1, 10'd2, 1'b0);
    send_request(OP_OFFER, 8'h55, 1'b0, 10'd0, 1'b0);
    // unused operation code
    send_request(OP_UNUSED, 8'hFF, 1'b1, 10'h3FF, 1'b1);
  endtask

  task automatic test_burst_control();
    send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b1);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
    // queue a message while the burst is in flight, then retire it
    offer_message(3, 1);
    send_request(OP_DONE, 8'h00, 1'b1, 10'h3FF, 1'b1);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
    offer_message(0, 2);
    send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    send_request(OP_OFFER, 8'h99, 1'b0, 10'd0, 1'b0);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
    send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    // ring now empty
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
  endtask

  // Fill the ring to the last byte, probe both sides of the limit, then empty it
  task automatic test_fill_ring();
    int room;
    if (burst_busy) send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    while (ring_free() >= 64) begin
      room = $urandom_range(1, 63);
      offer_message(room, room);
    end
    room = ring_free();
    offer_message(room + 1, 3);
    offer_message(room, room);
    offer_message(1, 1);
    while (head_idx != tail_idx) begin
      send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
      send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    end
  endtask

  task automatic test_random_traffic(input int count, input bit allow_gaps);
    int goal;
    int pick;
    int declared;
    int sent;
    goal    = requests_sent + count;
    gaps_on = allow_gaps;
    while (requests_sent < goal) begin
      if (allow_gaps && $urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)      declared = $urandom_range(1, 16);
        else if (pick < 90) declared = $urandom_range(17, 120);
        else                declared = $urandom_range(0, 1023);
        if (declared == 0 || declared > ring_free()) begin
          sent = $urandom_range(1, 3);
        end else begin
          pick = $urandom_range(0, 9);
          if (pick == 0)      sent = $urandom_range(1, declared);
          else if (pick == 1) sent = declared + $urandom_range(1, 3);
          else                sent = declared;
        end
        offer_message(declared, sent);
      end else if (pick < 75) begin
        send_request(OP_KICK, 8'($urandom), 1'($urandom), 10'($urandom),
                     $urandom_range(0, 4) == 0);
      end else if (pick < 88) begin
        send_request(OP_DONE, 8'($urandom), 1'($urandom), 10'($urandom), 1'($urandom));
      end else begin
        send_request(2'($urandom), 8'($urandom), 1'($urandom), 10'($urandom),
                     1'($urandom));
      end
      if (allow_gaps && $urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  // Pause with a burst in flight until all status has returned, then resume
  task automatic test_pause_for_results();
    offer_message(5, 5);
    send_request(OP_KICK, 8'h00, 1'b0, 10'd0, 1'b0);
    drain_results();
    send_request(OP_DONE, 8'h00, 1'b0, 10'd0, 1'b0);
    drain_results();
    offer_message(2, 2);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each returned status against the oldest prediction
  always @(posedge clk) begin
    ring_status_t want;
    if (rst_n && out_valid) begin
      if (ring_status_q.size() == 0) begin
        $display("%0t: status with no request pending, expected none, actual %0h",
                 $time, {out_accepted, out_burst_issued, out_burst_start, out_burst_length,
                         out_free_space, out_busy_res, out_drop_total});
        fail_count++;
      end else begin
        want = ring_status_q.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_accepted));
        check_field("burst_issued", 32'(want.burst_issued), 32'(out_burst_issued));
        check_field("burst_start", 32'(want.burst_start), 32'(out_burst_start));
        check_field("burst_length", 32'(want.burst_length), 32'(out_burst_length));
        check_field("free_space", 32'(want.free_space), 32'(out_free_space));
        check_field("busy_res", 32'(want.busy_res), 32'(out_busy_res));
        check_field("drop_total", want.drop_total, out_drop_total);
      end
    end
  end

  // Stop a hung run: count cycles where neither side moves anything
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_operation      <= OP_OFFER;
    in_data_byte      <= 8'h00;
    in_first_byte     <= 1'b0;
    in_message_length <= 10'd0;
    in_start_refused  <= 1'b0;
    stall_cycles      <= 0;
    head_idx      = 0;
    tail_idx      = 0;
    burst_bytes   = 0;
    burst_busy    = 0;
    drops_pred    = '0;
    msg_left      = 0;
    msg_open      = 0;
    fail_count    = 0;
    requests_sent = 0;
    gaps_on       = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_message_intake();
    test_burst_control();
    test_fill_ring();
    test_random_traffic(150, 1'b1);
    test_pause_for_results();
    test_random_traffic(80, 1'b0);

    drain_results();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
